/* rtl/fps_pkg.sv */
`timescale 1ns / 1ps

package fps_pkg;

  localparam int FRAC_BITS = 16;

  // tan(fov/2) unit
  localparam int CORDIC_STEPS = 30;
  localparam logic [25:0] DEG2RAD_HALF = 26'd37480660;
  localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
  localparam int TAN_NUM_W = 34 + FRAC_BITS;
  localparam int TAN_CNT_W = $clog2(TAN_NUM_W);

  // plane pipeline
  localparam int SQRT_ITERS = 32;
  localparam int SQRT_PER = 2;
  localparam int SQRT_STAGES = SQRT_ITERS / SQRT_PER;
  localparam int DIV_STEPS = FRAC_BITS + 2;
  localparam int DIV_PER = 2;
  localparam int DIV_STAGES = (DIV_STEPS + DIV_PER - 1) / DIV_PER;
  localparam int REM_W = 34 + FRAC_BITS;
  localparam int XP_W = 34;
  localparam int OP_W = 64 - FRAC_BITS;

  typedef logic signed [31:0] q_t;
  typedef q_t [2:0] vec3_t;

  localparam q_t Q_MAX = 32'sh7fffffff;
  localparam q_t Q_MIN = 32'sh80000000;

  typedef enum logic [2:0] {
    PL_TOP    = 3'd0,
    PL_BOTTOM = 3'd1,
    PL_LEFT   = 3'd2,
    PL_RIGHT  = 3'd3,
    PL_NEAR   = 3'd4,
    PL_FAR    = 3'd5
  } plane_e;

  typedef enum logic [1:0] {
    REG_FOV    = 2'd0,
    REG_ASPECT = 2'd1,
    REG_NEAR   = 2'd2,
    REG_FAR    = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    TS_IDLE,
    TS_ANGLE,
    TS_ROTATE,
    TS_PREP,
    TS_DIVIDE,
    TS_FINISH,
    TS_HEIGHT,
    TS_WIDTH
  } tan_state_e;

  // carried through the root and divide stages
  typedef struct packed {
    plane_e k;
    vec3_t  d;
    vec3_t  p;
    vec3_t  vec;
  } plane_t;

  function automatic logic signed [63:0] ext64(input q_t a);
    return 64'(a);
  endfunction

  function automatic q_t sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return Q_MAX;
    end else if (v < -64'sd2147483648) begin
      return Q_MIN;
    end
    return v[31:0];
  endfunction

  // a*b >> FRAC_BITS, floor, unsaturated
  function automatic logic signed [63:0] mulq(input q_t a, input q_t b);
    logic signed [63:0] p;
    p = ext64(a) * ext64(b);
    return p >>> FRAC_BITS;
  endfunction

  function automatic q_t neg_sat(input q_t a);
    return (a == Q_MIN) ? Q_MAX : -a;
  endfunction

  function automatic logic signed [32:0] atan_q30(input logic [4:0] i);
    case (i)
      5'd0:    return 33'sd843314857;
      5'd1:    return 33'sd497837829;
      5'd2:    return 33'sd263043837;
      5'd3:    return 33'sd133525159;
      5'd4:    return 33'sd67021687;
      5'd5:    return 33'sd33543516;
      5'd6:    return 33'sd16775851;
      5'd7:    return 33'sd8388437;
      5'd8:    return 33'sd4194283;
      5'd9:    return 33'sd2097149;
      5'd10:   return 33'sd1048576;
      default: return 33'sd1 <<< (5'd30 - i);
    endcase
  endfunction

endpackage

/* rtl/fps_tan_unit.sv */
`timescale 1ns / 1ps

module fps_tan_unit import fps_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [23:0] fov_i,
  input  logic [30:0] aspect_i,
  input  logic [30:0] near_i,
  output q_t          near_h_o,
  output q_t          near_w_o,
  output logic        busy_o
);

  tan_state_e state_q, state_d;
  logic [TAN_CNT_W-1:0] step_q, step_d;
  logic signed [32:0] z_q, z_d;
  logic signed [33:0] x_q, x_d, y_q, y_d;
  logic [34:0] rem_q, rem_d;
  logic [TAN_NUM_W-1:0] quo_q, quo_d;
  logic neg_q, neg_d;
  q_t tan_q, tan_d, nh_q, nh_d, nw_q, nw_d;

  logic [49:0] ang_prod;
  logic [32:0] ang;
  logic signed [33:0] xs, ys;
  logic signed [32:0] a_step;
  logic [34:0] rem_sh;
  logic [33:0] y_mag;

  assign ang_prod = 50'(fov_i) * 50'(DEG2RAD_HALF);
  assign ang      = 33'(ang_prod >> (FRAC_BITS + 2));
  assign xs       = x_q >>> step_q;
  assign ys       = y_q >>> step_q;
  assign a_step   = atan_q30(step_q[4:0]);
  assign rem_sh   = {rem_q[33:0], quo_q[TAN_NUM_W-1]};
  assign y_mag    = y_q[33] ? 34'(-y_q) : 34'(y_q);

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    z_d     = z_q;
    x_d     = x_q;
    y_d     = y_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    neg_d   = neg_q;
    tan_d   = tan_q;
    nh_d    = nh_q;
    nw_d    = nw_q;
    case (state_q)
      TS_IDLE: ;
      TS_ANGLE: begin
        z_d    = $signed(ang);
        x_d    = 34'sd1 <<< 30;
        y_d    = '0;
        step_d = '0;
        if (ang >= 33'(HALF_PI_Q30)) begin
          tan_d   = Q_MAX;
          state_d = TS_HEIGHT;
        end else begin
          state_d = TS_ROTATE;
        end
      end
      TS_ROTATE: begin
        if (z_q >= 0) begin
          x_d = x_q - ys;
          y_d = y_q + xs;
          z_d = z_q - a_step;
        end else begin
          x_d = x_q + ys;
          y_d = y_q - xs;
          z_d = z_q + a_step;
        end
        step_d = step_q + 1'b1;
        if (step_q == TAN_CNT_W'(CORDIC_STEPS - 1)) begin
          state_d = TS_PREP;
        end
      end
      TS_PREP: begin
        step_d = '0;
        rem_d  = '0;
        neg_d  = y_q[33];
        quo_d  = TAN_NUM_W'(y_mag) << FRAC_BITS;
        if (x_q <= 0) begin
          tan_d   = Q_MAX;
          state_d = TS_HEIGHT;
        end else begin
          state_d = TS_DIVIDE;
        end
      end
      TS_DIVIDE: begin
        if (rem_sh >= 35'(x_q)) begin
          rem_d = rem_sh - 35'(x_q);
          quo_d = {quo_q[TAN_NUM_W-2:0], 1'b1};
        end else begin
          rem_d = rem_sh;
          quo_d = {quo_q[TAN_NUM_W-2:0], 1'b0};
        end
        step_d = step_q + 1'b1;
        if (step_q == TAN_CNT_W'(TAN_NUM_W - 1)) begin
          state_d = TS_FINISH;
        end
      end
      TS_FINISH: begin
        if (!neg_q) begin
          tan_d = (quo_q > TAN_NUM_W'(Q_MAX)) ? Q_MAX : quo_q[31:0];
        end else begin
          tan_d = (quo_q > (TAN_NUM_W'(1) << 31)) ? Q_MIN : -quo_q[31:0];
        end
        state_d = TS_HEIGHT;
      end
      TS_HEIGHT: begin
        nh_d    = sat32(mulq({1'b0, near_i}, tan_q));
        state_d = TS_WIDTH;
      end
      TS_WIDTH: begin
        nw_d    = sat32(mulq(nh_q, {1'b0, aspect_i}));
        state_d = TS_IDLE;
      end
      default: state_d = TS_ANGLE;
    endcase
    if (start_i) begin
      state_d = TS_ANGLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= TS_ANGLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q <= step_d;
    z_q    <= z_d;
    x_q    <= x_d;
    y_q    <= y_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    neg_q  <= neg_d;
    tan_q  <= tan_d;
    nh_q   <= nh_d;
    nw_q   <= nw_d;
  end

  assign near_h_o = nh_q;
  assign near_w_o = nw_q;
  assign busy_o   = (state_q != TS_IDLE);

endmodule

/* rtl/frustum_plane_setup_top.sv */
`timescale 1ns / 1ps

// channel   | direction | handshake                 | payload
// ----------+-----------+---------------------------+---------------------------------
// camera    | in        | in_valid_i / in_stall_o   | right_*, up_*, fwd_*, cam_*
// plane     | out       | out_valid_o / out_stall_i | plane_index, normal_*, offset, last
// config    | in        | APB psel/penable/pwrite   | fov, aspect, near, far
//
// A camera request is taken as the last plane of the one before issues; the plane issue counter
// sends one plane per cycle unless out_stall_i holds the output. After reset and after every
// register write, tan(fov/2), near height and width are rebuilt (30 CORDIC steps, 50 divide
// steps); in_stall_o is high meanwhile. out_stall_i freezes the whole pipeline in place while
// a plane is held at the output; nothing is dropped or repeated.

module frustum_plane_setup_top import fps_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] right_x_i,
  input  logic [31:0] right_y_i,
  input  logic [31:0] right_z_i,
  input  logic [31:0] up_x_i,
  input  logic [31:0] up_y_i,
  input  logic [31:0] up_z_i,
  input  logic [31:0] fwd_x_i,
  input  logic [31:0] fwd_y_i,
  input  logic [31:0] fwd_z_i,
  input  logic [31:0] cam_x_i,
  input  logic [31:0] cam_y_i,
  input  logic [31:0] cam_z_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  plane_index_o,
  output logic [31:0] normal_x_o,
  output logic [31:0] normal_y_o,
  output logic [31:0] normal_z_o,
  output logic [31:0] plane_offset_o,
  output logic        last_plane_o
);

  typedef struct packed {
    plane_e k;
    vec3_t  c;
    vec3_t  f;
    vec3_t  axis;
    vec3_t  vec;
    q_t     len;
    q_t     depth;
  } job_t;

  typedef struct packed {
    plane_e k;
    vec3_t  c;
    vec3_t  vec;
    vec3_t  mf;
    vec3_t  ms;
  } s2_t;

  typedef struct packed {
    plane_e k;
    vec3_t  c;
    vec3_t  vec;
    vec3_t  nc;
    vec3_t  ms;
  } s3_t;

  typedef struct packed {
    plane_e k;
    vec3_t  c;
    vec3_t  vec;
    vec3_t  p;
  } s4_t;

  typedef logic [2:0][REM_W-1:0]   rem3_t;
  typedef logic [2:0][DIV_STEPS-1:0] quo3_t;
  typedef logic signed [XP_W-1:0] xp_t;

  typedef struct packed {
    plane_e     k;
    vec3_t      p;
    vec3_t      vec;
    xp_t [5:0]  xp;
  } x1_t;

  typedef struct packed {
    plane_e k;
    vec3_t  p;
    vec3_t  n;
  } x2_t;

  typedef struct packed {
    plane_e                 k;
    vec3_t                  n;
    logic [2:0][OP_W-1:0]   op;
  } o1_t;

  typedef struct packed {
    plane_e k;
    vec3_t  n;
    q_t     off;
  } out_t;

  // ---------------- configuration ----------------
  logic [23:0] fov_q;
  logic [30:0] aspect_q, near_q, far_q;
  logic        cfg_we;
  cfg_reg_e    cfg_idx;

  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = cfg_reg_e'(paddr[3:2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fov_q    <= 24'd3932160;
      aspect_q <= 31'd87381;
      near_q   <= 31'd6554;
      far_q    <= 31'd65536000;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_FOV:    fov_q    <= pwdata[23:0];
        REG_ASPECT: aspect_q <= pwdata[30:0];
        REG_NEAR:   near_q   <= pwdata[30:0];
        REG_FAR:    far_q    <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_FOV:    prdata = {8'd0, fov_q};
      REG_ASPECT: prdata = {1'b0, aspect_q};
      REG_NEAR:   prdata = {1'b0, near_q};
      REG_FAR:    prdata = {1'b0, far_q};
      default:    prdata = '0;
    endcase
  end

  q_t   near_h, near_w;
  logic tan_busy;

  fps_tan_unit u_tan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cfg_we),
    .fov_i    (fov_q),
    .aspect_i (aspect_q),
    .near_i   (near_q),
    .near_h_o (near_h),
    .near_w_o (near_w),
    .busy_o   (tan_busy)
  );

  // ---------------- request register and plane issue ----------------
  logic   en;
  logic   out_v_q;
  logic   item_v_q;
  plane_e cnt_q;
  vec3_t  r_q, u_q, f_q, c_q;
  logic   issue, last_issue, accept;

  assign en         = !out_v_q || !out_stall_i;
  assign issue      = item_v_q && en;
  assign last_issue = issue && (cnt_q == PL_FAR);
  assign in_stall_o = tan_busy || (item_v_q && !last_issue);
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_v_q <= 1'b0;
      cnt_q    <= PL_TOP;
    end else if (accept) begin
      item_v_q <= 1'b1;
      cnt_q    <= PL_TOP;
    end else if (issue) begin
      item_v_q <= !last_issue;
      cnt_q    <= plane_e'(cnt_q + 3'd1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      r_q <= {right_z_i, right_y_i, right_x_i};
      u_q <= {up_z_i, up_y_i, up_x_i};
      f_q <= {fwd_z_i, fwd_y_i, fwd_x_i};
      c_q <= {cam_z_i, cam_y_i, cam_x_i};
    end
  end

  job_t job;
  always_comb begin
    job.k     = cnt_q;
    job.c     = c_q;
    job.f     = f_q;
    job.axis  = u_q;
    job.vec   = r_q;
    job.len   = near_h;
    job.depth = {1'b0, near_q};
    case (cnt_q)
      PL_TOP, PL_BOTTOM: ;
      PL_LEFT, PL_RIGHT: begin
        job.axis = r_q;
        job.vec  = u_q;
        job.len  = near_w;
      end
      PL_NEAR: begin
        job.len = '0;
        for (int i = 0; i < 3; i++) begin
          job.vec[i] = neg_sat(f_q[i]);
        end
      end
      PL_FAR: begin
        job.len   = '0;
        job.vec   = f_q;
        job.depth = {1'b0, far_q};
      end
      default: ;
    endcase
  end

  // ---------------- front stages: points and directions ----------------
  logic  s1_v_q, s2_v_q, s3_v_q, s4_v_q, s5_v_q, s6_v_q, s7_v_q;
  job_t  s1_q;
  s2_t   s2_q, s2_d;
  s3_t   s3_q, s3_d;
  s4_t   s4_q, s4_d;
  plane_t s5_q, s5_d;
  plane_t s6_q;
  logic [2:0][63:0] s6_sq_q, s6_sq_d;
  plane_t s7_q;
  logic [63:0] s7_sum_q, s7_sum_d;

  always_comb begin
    s2_d.k   = s1_q.k;
    s2_d.c   = s1_q.c;
    s2_d.vec = s1_q.vec;
    for (int i = 0; i < 3; i++) begin
      s2_d.mf[i] = sat32(mulq(s1_q.f[i], s1_q.depth));
      s2_d.ms[i] = sat32(mulq(s1_q.axis[i], s1_q.len));
    end
  end

  always_comb begin
    s3_d.k   = s2_q.k;
    s3_d.c   = s2_q.c;
    s3_d.vec = s2_q.vec;
    s3_d.ms  = s2_q.ms;
    for (int i = 0; i < 3; i++) begin
      s3_d.nc[i] = sat32(ext64(s2_q.c[i]) - ext64(s2_q.mf[i]));
    end
  end

  always_comb begin
    s4_d.k   = s3_q.k;
    s4_d.c   = s3_q.c;
    s4_d.vec = s3_q.vec;
    for (int i = 0; i < 3; i++) begin
      if (s3_q.k == PL_TOP || s3_q.k == PL_RIGHT) begin
        s4_d.p[i] = sat32(ext64(s3_q.nc[i]) + ext64(s3_q.ms[i]));
      end else if (s3_q.k == PL_BOTTOM || s3_q.k == PL_LEFT) begin
        s4_d.p[i] = sat32(ext64(s3_q.nc[i]) - ext64(s3_q.ms[i]));
      end else begin
        s4_d.p[i] = s3_q.nc[i];
      end
    end
  end

  always_comb begin
    s5_d.k   = s4_q.k;
    s5_d.p   = s4_q.p;
    s5_d.vec = s4_q.vec;
    for (int i = 0; i < 3; i++) begin
      s5_d.d[i] = sat32(ext64(s4_q.p[i]) - ext64(s4_q.c[i]));
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s6_sq_d[i] = ext64(s5_q.d[i]) * ext64(s5_q.d[i]);
    end
  end

  assign s7_sum_d = s6_sq_q[0] + s6_sq_q[1] + s6_sq_q[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
      s5_v_q <= 1'b0;
      s6_v_q <= 1'b0;
      s7_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= issue;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q;
      s5_v_q <= s4_v_q;
      s6_v_q <= s5_v_q;
      s7_v_q <= s6_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q     <= job;
      s2_q     <= s2_d;
      s3_q     <= s3_d;
      s4_q     <= s4_d;
      s5_q     <= s5_d;
      s6_q     <= s5_q;
      s6_sq_q  <= s6_sq_d;
      s7_q     <= s6_q;
      s7_sum_q <= s7_sum_d;
    end
  end

  // ---------------- integer square root, two bits per stage ----------------
  logic        sq_v_q    [SQRT_STAGES];
  plane_t      sq_pl_q   [SQRT_STAGES];
  logic [63:0] sq_val_q  [SQRT_STAGES];
  logic [63:0] sq_root_q [SQRT_STAGES];
  logic        sq_in_v   [SQRT_STAGES];
  plane_t      sq_in_pl  [SQRT_STAGES];
  logic [63:0] sq_in_val [SQRT_STAGES];
  logic [63:0] sq_in_root[SQRT_STAGES];

  for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_sqrt
    localparam int J0 = g * SQRT_PER;
    logic [63:0] val_d, root_d;

    if (g == 0) begin : g_first
      assign sq_in_v[g]    = s7_v_q;
      assign sq_in_pl[g]   = s7_q;
      assign sq_in_val[g]  = s7_sum_q;
      assign sq_in_root[g] = '0;
    end else begin : g_next
      assign sq_in_v[g]    = sq_v_q[g-1];
      assign sq_in_pl[g]   = sq_pl_q[g-1];
      assign sq_in_val[g]  = sq_val_q[g-1];
      assign sq_in_root[g] = sq_root_q[g-1];
    end

    always_comb begin
      logic [63:0] bit_w;
      val_d  = sq_in_val[g];
      root_d = sq_in_root[g];
      for (int t = 0; t < SQRT_PER; t++) begin
        bit_w = 64'd1 << (62 - 2 * (J0 + t));
        if (val_d >= root_d + bit_w) begin
          val_d  = val_d - (root_d + bit_w);
          root_d = (root_d >> 1) + bit_w;
        end else begin
          root_d = root_d >> 1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_v_q[g] <= 1'b0;
      end else if (en) begin
        sq_v_q[g] <= sq_in_v[g];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_pl_q[g]   <= sq_in_pl[g];
        sq_val_q[g]  <= val_d;
        sq_root_q[g] <= root_d;
      end
    end
  end

  // ---------------- unit vector: restoring divide, two bits per stage ----------------
  logic        dv_v_q    [DIV_STAGES];
  plane_t      dv_pl_q   [DIV_STAGES];
  logic [31:0] dv_len_q  [DIV_STAGES];
  rem3_t       dv_rem_q  [DIV_STAGES];
  quo3_t       dv_quo_q  [DIV_STAGES];
  logic        dv_in_v   [DIV_STAGES];
  plane_t      dv_in_pl  [DIV_STAGES];
  logic [31:0] dv_in_len [DIV_STAGES];
  rem3_t       dv_in_rem [DIV_STAGES];
  quo3_t       dv_in_quo [DIV_STAGES];

  rem3_t rem_init;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [31:0] mag;
      mag = sq_pl_q[SQRT_STAGES-1].d[i][31] ? 32'(-sq_pl_q[SQRT_STAGES-1].d[i])
                                            : 32'(sq_pl_q[SQRT_STAGES-1].d[i]);
      rem_init[i] = REM_W'(mag) << FRAC_BITS;
    end
  end

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    localparam int I0 = g * DIV_PER;
    rem3_t rem_d;
    quo3_t quo_d;

    if (g == 0) begin : g_first
      assign dv_in_v[g]   = sq_v_q[SQRT_STAGES-1];
      assign dv_in_pl[g]  = sq_pl_q[SQRT_STAGES-1];
      assign dv_in_len[g] = sq_root_q[SQRT_STAGES-1][31:0];
      assign dv_in_rem[g] = rem_init;
      assign dv_in_quo[g] = '0;
    end else begin : g_next
      assign dv_in_v[g]   = dv_v_q[g-1];
      assign dv_in_pl[g]  = dv_pl_q[g-1];
      assign dv_in_len[g] = dv_len_q[g-1];
      assign dv_in_rem[g] = dv_rem_q[g-1];
      assign dv_in_quo[g] = dv_quo_q[g-1];
    end

    always_comb begin
      logic [REM_W-1:0] trial;
      rem_d = dv_in_rem[g];
      quo_d = dv_in_quo[g];
      for (int t = 0; t < DIV_PER; t++) begin
        if (I0 + t < DIV_STEPS) begin
          trial = REM_W'(dv_in_len[g]) << (DIV_STEPS - 1 - (I0 + t));
          for (int i = 0; i < 3; i++) begin
            if (rem_d[i] >= trial) begin
              rem_d[i] = rem_d[i] - trial;
              quo_d[i][DIV_STEPS - 1 - (I0 + t)] = 1'b1;
            end
          end
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[g] <= 1'b0;
      end else if (en) begin
        dv_v_q[g] <= dv_in_v[g];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_pl_q[g]  <= dv_in_pl[g];
        dv_len_q[g] <= dv_in_len[g];
        dv_rem_q[g] <= rem_d;
        dv_quo_q[g] <= quo_d;
      end
    end
  end

  // ---------------- cross product and offset ----------------
  plane_t dv_last;
  vec3_t  unit;
  x1_t    x1_q, x1_d;
  x2_t    x2_q, x2_d;
  o1_t    o1_q, o1_d;
  out_t   out_q, out_d;
  logic   x1_v_q, x2_v_q, o1_v_q;

  assign dv_last = dv_pl_q[DIV_STAGES-1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [31:0] qz;
      qz = 32'(dv_quo_q[DIV_STAGES-1][i]);
      if (dv_len_q[DIV_STAGES-1] == '0) begin
        unit[i] = '0;
      end else if (dv_last.d[i][31]) begin
        unit[i] = -qz;
      end else begin
        unit[i] = qz;
      end
    end
  end

  always_comb begin
    x1_d.k     = dv_last.k;
    x1_d.p     = dv_last.p;
    x1_d.vec   = dv_last.vec;
    x1_d.xp[0] = XP_W'(mulq(unit[1], dv_last.vec[2]));
    x1_d.xp[1] = XP_W'(mulq(unit[2], dv_last.vec[1]));
    x1_d.xp[2] = XP_W'(mulq(unit[2], dv_last.vec[0]));
    x1_d.xp[3] = XP_W'(mulq(unit[0], dv_last.vec[2]));
    x1_d.xp[4] = XP_W'(mulq(unit[0], dv_last.vec[1]));
    x1_d.xp[5] = XP_W'(mulq(unit[1], dv_last.vec[0]));
  end

  always_comb begin
    x2_d.k = x1_q.k;
    x2_d.p = x1_q.p;
    for (int i = 0; i < 3; i++) begin
      if (x1_q.k == PL_NEAR || x1_q.k == PL_FAR) begin
        x2_d.n[i] = x1_q.vec[i];
      end else begin
        x2_d.n[i] = sat32(64'($signed(x1_q.xp[2*i])) - 64'($signed(x1_q.xp[2*i+1])));
      end
    end
  end

  always_comb begin
    o1_d.k = x2_q.k;
    o1_d.n = x2_q.n;
    for (int i = 0; i < 3; i++) begin
      o1_d.op[i] = OP_W'(mulq(x2_q.n[i], x2_q.p[i]));
    end
  end

  always_comb begin
    logic signed [63:0] s;
    s = 64'($signed(o1_q.op[0])) + 64'($signed(o1_q.op[1])) + 64'($signed(o1_q.op[2]));
    out_d.k   = o1_q.k;
    out_d.n   = o1_q.n;
    out_d.off = sat32(-s);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x1_v_q  <= 1'b0;
      x2_v_q  <= 1'b0;
      o1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      x1_v_q  <= dv_v_q[DIV_STAGES-1];
      x2_v_q  <= x1_v_q;
      o1_v_q  <= x2_v_q;
      out_v_q <= o1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x1_q  <= x1_d;
      x2_q  <= x2_d;
      o1_q  <= o1_d;
      out_q <= out_d;
    end
  end

  assign out_valid_o    = out_v_q;
  assign plane_index_o  = out_q.k;
  assign normal_x_o     = out_q.n[0];
  assign normal_y_o     = out_q.n[1];
  assign normal_z_o     = out_q.n[2];
  assign plane_offset_o = out_q.off;
  assign last_plane_o   = (out_q.k == PL_FAR);

  // ---------------- checks ----------------
  a_busy_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tan_busy |-> in_stall_o)
    else $error("request taken while tangent unit busy");

  a_accept_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> item_v_q && cnt_q == PL_TOP)
    else $error("accepted request not loaded at top plane");

  a_planes_in_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !out_stall_i && out_q.k != PL_FAR
    |=> out_v_q && out_q.k == plane_e'($past(out_q.k) + 3'd1))
    else $error("planes of one camera not delivered back to back in order");

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import fps_pkg::*;

  typedef q_t [11:0] camera_t;  // right xyz, up xyz, fwd xyz, cam xyz

  typedef struct {
    plane_e k;
    q_t     nx;
    q_t     ny;
    q_t     nz;
    q_t     off;
    logic   last;
  } plane_exp_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [31:0] cam_f [12];
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  plane_index_o;
  logic [31:0] normal_x_o;
  logic [31:0] normal_y_o;
  logic [31:0] normal_z_o;
  logic [31:0] plane_offset_o;
  logic        last_plane_o;

  plane_exp_t planes_q [$];
  longint     fov_cfg, aspect_cfg, near_cfg, far_cfg;
  int         mismatches = 0;
  int         idle_mode = 2;  // 0: sender 18 / receiver 58, 1: reversed, 2: none
  int         stuck_cycles = 0;

  always #6 clk_i = ~clk_i;

  initial begin
    for (int i = 0; i < 12; i++) cam_f[i] = '0;
  end

  frustum_plane_setup_top u_dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_stall_o,
    .right_x_i(cam_f[0]), .right_y_i(cam_f[1]), .right_z_i(cam_f[2]),
    .up_x_i(cam_f[3]), .up_y_i(cam_f[4]), .up_z_i(cam_f[5]),
    .fwd_x_i(cam_f[6]), .fwd_y_i(cam_f[7]), .fwd_z_i(cam_f[8]),
    .cam_x_i(cam_f[9]), .cam_y_i(cam_f[10]), .cam_z_i(cam_f[11]),
    .out_valid_o, .out_stall_i, .plane_index_o, .normal_x_o, .normal_y_o, .normal_z_o,
    .plane_offset_o, .last_plane_o
  );

  // ---------------- plane predictor ----------------
  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return (a * b) >>> FRAC_BITS;
  endfunction

  function automatic longint half_fov_tan();
    longint z, x, y, a, xs, ys;
    z = (fov_cfg * 64'sd37480660) >>> (FRAC_BITS + 2);
    x = 64'sd1 <<< 30;
    y = 0;
    if (z >= 64'sd1686629713) return 64'sd2147483647;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      a = longint'(atan_q30(5'(i)));
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= a;
      end else begin
        x += ys; y -= xs; z += a;
      end
    end
    if (x <= 0) return 64'sd2147483647;
    return clamp32((y * (64'sd1 <<< FRAC_BITS)) / x);
  endfunction

  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint offset_of(longint n [3], longint p [3]);
    return clamp32(-(qmul(n[0], p[0]) + qmul(n[1], p[1]) + qmul(n[2], p[2])));
  endfunction

  function automatic void push_plane(plane_e k, longint n [3], longint off);
    plane_exp_t e;
    e.k = k;
    e.nx = q_t'(n[0]);
    e.ny = q_t'(n[1]);
    e.nz = q_t'(n[2]);
    e.off = q_t'(off);
    e.last = (k == PL_FAR);
    planes_q.push_back(e);
  endfunction

  function automatic void side_plane(plane_e k, longint nc [3], longint c [3],
                                     longint axis [3], longint len, bit add,
                                     longint other [3]);
    longint p [3], d [3], u [3], n [3], s;
    longint unsigned sq, l;
    sq = 0;
    for (int i = 0; i < 3; i++) begin
      s = clamp32(qmul(axis[i], len));
      p[i] = clamp32(add ? nc[i] + s : nc[i] - s);
      d[i] = clamp32(p[i] - c[i]);
      sq += longint'(d[i] * d[i]);
    end
    l = root64(sq);
    for (int i = 0; i < 3; i++)
      u[i] = (l == 0) ? 0 : (d[i] * (64'sd1 <<< FRAC_BITS)) / longint'(l);
    n[0] = clamp32(qmul(u[1], other[2]) - qmul(u[2], other[1]));
    n[1] = clamp32(qmul(u[2], other[0]) - qmul(u[0], other[2]));
    n[2] = clamp32(qmul(u[0], other[1]) - qmul(u[1], other[0]));
    push_plane(k, n, offset_of(n, p));
  endfunction

  function automatic void predict_planes(camera_t cm);
    longint r [3], up [3], f [3], c [3], nc [3], fc [3], nf [3];
    longint t, nh, nw;
    for (int i = 0; i < 3; i++) begin
      r[i] = longint'(cm[i]);
      up[i] = longint'(cm[3 + i]);
      f[i] = longint'(cm[6 + i]);
      c[i] = longint'(cm[9 + i]);
    end
    t = half_fov_tan();
    nh = clamp32(qmul(near_cfg, t));
    nw = clamp32(qmul(nh, aspect_cfg));
    for (int i = 0; i < 3; i++) begin
      nc[i] = clamp32(c[i] - clamp32(qmul(f[i], near_cfg)));
      fc[i] = clamp32(c[i] - clamp32(qmul(f[i], far_cfg)));
      nf[i] = clamp32(-f[i]);
    end
    side_plane(PL_TOP, nc, c, up, nh, 1'b1, r);
    side_plane(PL_BOTTOM, nc, c, up, nh, 1'b0, r);
    side_plane(PL_LEFT, nc, c, r, nw, 1'b0, up);
    side_plane(PL_RIGHT, nc, c, r, nw, 1'b1, up);
    push_plane(PL_NEAR, nf, offset_of(nf, nc));
    push_plane(PL_FAR, f, offset_of(f, fc));
  endfunction

  // ---------------- drivers ----------------
  task automatic reg_write(cfg_reg_e idx, logic [31:0] val);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_FOV:    fov_cfg = longint'(val[23:0]);
      REG_ASPECT: aspect_cfg = longint'(val[30:0]);
      REG_NEAR:   near_cfg = longint'(val[30:0]);
      default:    far_cfg = longint'(val[30:0]);
    endcase
  endtask

  // typed = 1: expectations already queued by the caller
  task automatic send_camera(camera_t cm, bit typed);
    int gap_pct;
    gap_pct = (idle_mode == 0) ? 18 : (idle_mode == 1) ? 58 : 0;
    for (int i = 0; i < 12; i++) cam_f[i] <= cm[i];
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    if (!typed) predict_planes(cm);
    if ($urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < gap_pct);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (planes_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic q_t pick_field();
    case ($urandom_range(0, 9))
      0:       return Q_MAX;
      1:       return Q_MIN;
      2:       return '0;
      3:       return ($urandom_range(0, 1) != 0) ? 32'sd65536 : -32'sd65536;
      4, 5:    return q_t'($urandom);
      default: return q_t'(int'($urandom_range(0, 262144)) - 131072);
    endcase
  endfunction

  function automatic camera_t pick_camera();
    camera_t cm;
    int ax;
    // mostly well-formed: axis-aligned unit basis with scattered noise
    ax = $urandom_range(0, 3);
    for (int i = 0; i < 12; i++) cm[i] = pick_field();
    if (ax != 3) begin
      for (int i = 0; i < 9; i++) cm[i] = '0;
      cm[0] = 32'sd65536;
      cm[4] = 32'sd65536;
      cm[8] = ($urandom_range(0, 1) != 0) ? 32'sd65536 : -32'sd65536;
      if (ax == 1) cm[$urandom_range(0, 8)] = pick_field();
      for (int i = 9; i < 12; i++) cm[i] = q_t'(int'($urandom_range(0, 2097152)) - 1048576);
    end
    return cm;
  endfunction

  // ---------------- receiver side ----------------
  always @(posedge clk_i) begin
    case (idle_mode)
      0:       out_stall_i <= ($urandom_range(0, 99) < 58);
      1:       out_stall_i <= ($urandom_range(0, 99) < 18);
      default: out_stall_i <= 1'b0;
    endcase
  end

  always @(posedge clk_i) begin
    plane_exp_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (planes_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected plane %0d", plane_index_o);
      end else begin
        e = planes_q.pop_front();
        if (plane_index_o !== e.k || normal_x_o !== e.nx || normal_y_o !== e.ny ||
            normal_z_o !== e.nz || plane_offset_o !== e.off || last_plane_o !== e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("plane mismatch: exp k%0d n(%h %h %h) off %h last %b, got k%0d n(%h %h %h) off %h last %b",
                     e.k, e.nx, e.ny, e.nz, e.off, e.last, plane_index_o, normal_x_o,
                     normal_y_o, normal_z_o, plane_offset_o, last_plane_o);
        end
      end
    end
  end

  // watchdog on handshake progress
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= 5000) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // ---------------- main sequence ----------------
  function automatic camera_t mk_cam(q_t rx, q_t ry, q_t rz, q_t ux, q_t uy, q_t uz,
                                     q_t fx, q_t fy, q_t fz, q_t cx, q_t cy, q_t cz);
    return {cz, cy, cx, fz, fy, fx, uz, uy, ux, rz, ry, rx};
  endfunction

  localparam q_t ONE = 32'sd65536;

  camera_t     dir_tab [8];
  logic [31:0] cfg_tab [9][4];

  initial begin
    plane_exp_t e;
    fov_cfg = 3932160;
    aspect_cfg = 87381;
    near_cfg = 6554;
    far_cfg = 65536000;

    dir_tab[0] = mk_cam('0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0);
    dir_tab[1] = mk_cam(ONE, '0, '0, '0, ONE, '0, '0, '0, ONE, '0, '0, '0);
    dir_tab[2] = mk_cam(ONE, '0, '0, '0, ONE, '0, '0, '0, -ONE, ONE, 2 * ONE, -3 * ONE);
    dir_tab[3] = mk_cam(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX,
                        Q_MAX, Q_MAX, Q_MAX);
    dir_tab[4] = mk_cam(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN,
                        Q_MIN, Q_MIN, Q_MIN);
    dir_tab[5] = mk_cam(Q_MAX, Q_MIN, '0, Q_MIN, Q_MAX, -1, Q_MIN, '0, Q_MAX, Q_MIN,
                        Q_MAX, 1);
    dir_tab[6] = mk_cam('0, '0, '0, '0, '0, '0, '0, '0, '0, Q_MAX, Q_MIN, ONE);
    dir_tab[7] = mk_cam('0, ONE, '0, '0, '0, ONE, ONE, '0, '0, -1, -1, -1);

    cfg_tab[0] = '{32'd65536, 32'd65536, 32'd65536, 32'd655360};
    cfg_tab[1] = '{32'd11730944, 32'h7fffffff, 32'd1, 32'h7fffffff};
    cfg_tab[2] = '{32'd0, 32'd1, 32'h7fffffff, 32'd1};
    cfg_tab[3] = '{32'hffffff, 32'd131072, 32'd32768, 32'd16777216};
    cfg_tab[4] = '{32'd5898240, 32'd87381, 32'd6554, 32'd65536000};
    for (int p = 5; p < 9; p++)
      cfg_tab[p] = '{$urandom_range(65536, 11730944), $urandom_range(1, 32'h7fffffff),
                     $urandom_range(1, 32'h7fffffff), $urandom_range(1, 32'h7fffffff)};

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < 8; r++) begin
      if (r == 0) begin
        // all-zero camera: every normal and offset is zero
        for (int k = 0; k < 6; k++) begin
          e.k = plane_e'(k);
          e.nx = '0; e.ny = '0; e.nz = '0; e.off = '0;
          e.last = (k == 5);
          planes_q.push_back(e);
        end
      end
      send_camera(dir_tab[r], r == 0);
    end

    for (int p = 0; p < 9; p++) begin
      drain();
      reg_write(REG_FOV, cfg_tab[p][0]);
      reg_write(REG_ASPECT, cfg_tab[p][1]);
      reg_write(REG_NEAR, cfg_tab[p][2]);
      reg_write(REG_FAR, cfg_tab[p][3]);
      idle_mode = p / 3;
      for (int n = 0; n < 22; n++) send_camera(pick_camera(), 1'b0);
    end

    drain();
    repeat (60) @(posedge clk_i);
    if (mismatches == 0 && planes_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/fps_pkg.sv
rtl/fps_tan_unit.sv
rtl/frustum_plane_setup_top.sv
sim/testbench.sv
